### design/rvcc_pkg.sv
// Shared widths, constants, register indexes and types of the voltage code converter.
package rvcc_pkg;

  // Item fields
  localparam int KIND_W  = 1;
  localparam int VALUE_W = 16;

  // Configuration registers
  localparam int FMT_W      = 3;
  localparam int BUV_W      = 22;
  localparam int STEP_W     = 24;
  localparam int BCODE_W    = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);

  typedef enum logic [1:0] {
    REG_CODE_FORMAT = 2'd0,
    REG_BASE_UV     = 2'd1,
    REG_STEP_NV     = 2'd2,
    REG_BASE_CODE   = 2'd3
  } reg_idx_t;

  // Code formats
  localparam logic [FMT_W-1:0] FMT_VID     = 3'd0;
  localparam logic [FMT_W-1:0] FMT_STEP    = 3'd1;
  localparam logic [FMT_W-1:0] FMT_LIN_M12 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_LIN_M9  = 3'd3;

  // Arithmetic constants
  localparam int VID_BASE_MV = 245;
  localparam int VID_STEP_MV = 5;
  localparam int NV_PER_MV   = 1000000;
  localparam int NV_PER_UV   = 1000;
  localparam int MV_DIV      = 1000;
  localparam int ROUND_HALF  = 500;
  localparam int LIN12_ROUND = 2048;
  localparam int LIN12_SHIFT = 12;
  localparam int LIN9_ROUND  = 256;
  localparam int LIN9_SHIFT  = 9;

  // Divider A takes every run-time division; the final /1000 of step decode is a
  // reciprocal multiply on a NUMB_W-bit magnitude
  localparam int NUMA_W = 39;
  localparam int DENA_W = STEP_W;
  localparam int NUMB_W = 30;
  localparam int XA_W   = 41;   // signed value ahead of divider A
  localparam int XB_W   = 41;   // signed value ahead of the final /1000

  // ceil(2^40 / 1000): exact truncating /1000 for any magnitude below 2^30
  localparam int                    NUMB_HALF_W    = 15;
  localparam int                    MV_RECIP_W     = 31;
  localparam int                    MV_RECIP_SHIFT = 40;
  localparam logic [MV_RECIP_W-1:0] MV_RECIP       = MV_RECIP_W'(1099511628);

  typedef struct packed {
    logic [FMT_W-1:0]   code_format;
    logic [BUV_W-1:0]   base_uv;
    logic [STEP_W-1:0]  step_nv;
    logic [BCODE_W-1:0] base_code;
  } cfg_t;

  typedef enum logic [1:0] {
    PATH_DIRECT   = 2'd0,   // result already known, carried alongside
    PATH_DIVQ     = 2'd1,   // result is the low bits of quotient A
    PATH_STEP_C2M = 2'd2,   // step format, code to millivolts
    PATH_STEP_M2C = 2'd3    // step format, millivolts to code
  } path_t;

  typedef struct packed {
    path_t              path;
    logic               neg;
    logic [VALUE_W-1:0] direct;
  } side_a_t;

  typedef struct packed {
    logic               step_c2m;
    logic               neg;
    logic [VALUE_W-1:0] res;
  } side_b_t;

  localparam int SIDEA_W = $bits(side_a_t);

endpackage

### design/rvcc_in_if.sv
// Input item channel: conversion direction and value.
interface rvcc_in_if;
  import rvcc_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

### design/rvcc_out_if.sv
// Result item channel: converted value.
interface rvcc_out_if;
  import rvcc_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] converted;

  modport source (output valid, output converted, input ready);
  modport sink   (input valid, input converted, output ready);
endinterface

### design/rvcc_cfg.sv
// APB-style configuration register file of the voltage code converter.
module rvcc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rvcc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rvcc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rvcc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output rvcc_pkg::cfg_t                 cfg
);
  import rvcc_pkg::*;

  logic [FMT_W-1:0]   fmt_r;
  logic [BUV_W-1:0]   buv_r;
  logic [STEP_W-1:0]  step_r;
  logic [BCODE_W-1:0] bcode_r;
  reg_idx_t           idx;
  logic               wr;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_VID;
      buv_r   <= '0;
      step_r  <= STEP_RESET;
      bcode_r <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_CODE_FORMAT: fmt_r   <= pwdata[FMT_W-1:0];
        REG_BASE_UV:     buv_r   <= pwdata[BUV_W-1:0];
        REG_STEP_NV:     step_r  <= pwdata[STEP_W-1:0];
        REG_BASE_CODE:   bcode_r <= pwdata[BCODE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CODE_FORMAT: prdata = APB_DATA_W'(fmt_r);
      REG_BASE_UV:     prdata = APB_DATA_W'(buv_r);
      REG_STEP_NV:     prdata = APB_DATA_W'(step_r);
      REG_BASE_CODE:   prdata = APB_DATA_W'(bcode_r);
    endcase
  end

  assign cfg.code_format = fmt_r;
  assign cfg.base_uv     = buv_r;
  assign cfg.step_nv     = step_r;
  assign cfg.base_code   = bcode_r;

endmodule

### design/rvcc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband that rides along.
module rvcc_div #(
  parameter int NUM_W  = rvcc_pkg::NUMA_W,
  parameter int DEN_W  = rvcc_pkg::DENA_W,
  parameter int SIDE_W = rvcc_pkg::SIDEA_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);
  import rvcc_pkg::*;

  // Element s feeds stage s; element s+1 is stage s's register
  logic              valid_q [NUM_W+1];
  logic [DEN_W-1:0]  rem_q   [NUM_W+1];
  logic [NUM_W-1:0]  work_q  [NUM_W+1];
  logic [DEN_W-1:0]  den_q   [NUM_W+1];
  logic [SIDE_W-1:0] side_q  [NUM_W+1];

  assign valid_q[0] = in_valid;
  assign rem_q[0]   = '0;
  assign work_q[0]  = in_num;
  assign den_q[0]   = in_den;
  assign side_q[0]  = in_side;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W:0]    trial;
    logic [DEN_W+1:0]  diff;
    logic              fits;
    logic [DEN_W-1:0]  rem_nxt;
    logic [NUM_W-1:0]  work_nxt;
    logic              valid_r;
    logic [DEN_W-1:0]  rem_r;
    logic [NUM_W-1:0]  work_r;
    logic [DEN_W-1:0]  den_r;
    logic [SIDE_W-1:0] side_r;

    // work holds the numerator bits still to come, quotient bits shift in at the bottom
    always_comb begin
      trial    = {rem_q[s], work_q[s][NUM_W-1]};
      diff     = {1'b0, trial} - {2'b00, den_q[s]};
      fits     = ~diff[DEN_W+1];
      rem_nxt  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      work_nxt = {work_q[s][NUM_W-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r <= 1'b0;
      end else if (en) begin
        valid_r <= valid_q[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        work_r <= work_nxt;
        den_r  <= den_q[s];
        side_r <= side_q[s];
      end
    end

    assign valid_q[s+1] = valid_r;
    assign rem_q[s+1]   = rem_r;
    assign work_q[s+1]  = work_r;
    assign den_q[s+1]   = den_r;
    assign side_q[s+1]  = side_r;
  end

  assign out_valid = valid_q[NUM_W];
  assign out_quo   = work_q[NUM_W];
  assign out_side  = side_q[NUM_W];

endmodule

### design/rvcc_prep.sv
// Operand preparation: products, format decode and signed magnitude for divider A.
module rvcc_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [rvcc_pkg::KIND_W-1:0]   in_kind,
  input  logic [rvcc_pkg::VALUE_W-1:0]  in_value,
  input  rvcc_pkg::cfg_t                cfg,
  output logic                          out_valid,
  output logic [rvcc_pkg::NUMA_W-1:0]   out_num,
  output logic [rvcc_pkg::DENA_W-1:0]   out_den,
  output rvcc_pkg::side_a_t             out_side
);
  import rvcc_pkg::*;

  localparam int VNV_W  = 36;   // millivolts times 1e6
  localparam int BNV_W  = 32;   // microvolts times 1000
  localparam int VK_W   = 26;   // code times 1000
  localparam int LIN_W  = 27;
  localparam int T_W    = 38;
  localparam int HALF_W = STEP_W - 1;

  // Stage 1: multipliers
  logic                     valid1_r;
  logic [KIND_W-1:0]        kind1_r;
  logic [VALUE_W-1:0]       v1_r;
  logic signed [XA_W-1:0]   prod1_r;
  logic [VNV_W-1:0]         vnv1_r;
  logic [BNV_W-1:0]         bnv1_r;
  logic [VK_W-1:0]          vk1_r;
  logic signed [VALUE_W-1:0] d1;
  logic signed [XA_W-1:0]   prod1_nxt;

  assign d1        = signed'(in_value - cfg.base_code);
  assign prod1_nxt = d1 * $signed({1'b0, cfg.step_nv});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else if (en) begin
      valid1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind1_r <= in_kind;
      v1_r    <= in_value;
      prod1_r <= prod1_nxt;
      vnv1_r  <= VNV_W'(in_value) * VNV_W'(NV_PER_MV);
      bnv1_r  <= BNV_W'(cfg.base_uv) * BNV_W'(NV_PER_UV);
      vk1_r   <= VK_W'(in_value) * VK_W'(MV_DIV);
    end
  end

  // Stage 2: format decode
  logic                     valid2_r;
  path_t                    path2_r;
  logic signed [XA_W-1:0]   x2_r;
  logic [HALF_W-1:0]        half2_r;
  logic [DENA_W-1:0]        den2_r;
  logic [VALUE_W-1:0]       direct2_r;
  path_t                    path2_nxt;
  logic signed [XA_W-1:0]   x2_nxt;
  logic [HALF_W-1:0]        half2_nxt;
  logic [DENA_W-1:0]        den2_nxt;
  logic [VALUE_W-1:0]       direct2_nxt;
  logic signed [T_W-1:0]    t2;
  logic [31:0]              vid_off;
  logic [LIN_W-1:0]         lin12;
  logic [LIN_W-1:0]         lin9;
  logic [STEP_W-1:0]        step_eff;
  logic                     v_zero;

  always_comb begin
    t2       = $signed({2'b00, vnv1_r}) - $signed({6'b0, bnv1_r});
    vid_off  = 32'(v1_r) - 32'(VID_BASE_MV);
    lin12    = LIN_W'(vk1_r) + LIN_W'(LIN12_ROUND);
    lin9     = LIN_W'(vk1_r) + LIN_W'(LIN9_ROUND);
    step_eff = (cfg.step_nv == '0) ? STEP_W'(1) : cfg.step_nv;
    v_zero   = (v1_r == '0);

    path2_nxt   = PATH_DIRECT;
    x2_nxt      = '0;
    half2_nxt   = '0;
    den2_nxt    = DENA_W'(MV_DIV);
    direct2_nxt = '0;

    unique case (cfg.code_format)
      FMT_VID: begin
        if (kind1_r == 1'b1) begin
          if (!v_zero) begin
            path2_nxt = PATH_DIVQ;
            x2_nxt    = $signed({9'b0, vid_off});
            den2_nxt  = DENA_W'(VID_STEP_MV);
          end
        end else if (!v_zero) begin
          direct2_nxt = VALUE_W'(VID_BASE_MV) + VALUE_W'(v1_r * VALUE_W'(VID_STEP_MV));
        end
      end
      FMT_STEP: begin
        if (kind1_r == 1'b1) begin
          path2_nxt = PATH_STEP_M2C;
          x2_nxt    = XA_W'(t2);
          half2_nxt = step_eff[STEP_W-1:1];
          den2_nxt  = step_eff;
        end else begin
          path2_nxt = PATH_STEP_C2M;
          x2_nxt    = prod1_r;
        end
      end
      FMT_LIN_M12: begin
        if (kind1_r == 1'b1) begin
          path2_nxt = PATH_DIVQ;
          x2_nxt    = $signed(XA_W'({v1_r, LIN12_SHIFT'(0)}) + XA_W'(ROUND_HALF));
        end else begin
          direct2_nxt = VALUE_W'(lin12 >> LIN12_SHIFT);
        end
      end
      FMT_LIN_M9: begin
        if (kind1_r == 1'b1) begin
          path2_nxt = PATH_DIVQ;
          x2_nxt    = $signed(XA_W'({v1_r, LIN9_SHIFT'(0)}) + XA_W'(ROUND_HALF));
        end else begin
          direct2_nxt = VALUE_W'(lin9 >> LIN9_SHIFT);
        end
      end
      default: begin
        // unsupported formats convert to zero
        path2_nxt = PATH_DIRECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid2_r <= 1'b0;
    end else if (en) begin
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      path2_r   <= path2_nxt;
      x2_r      <= x2_nxt;
      half2_r   <= half2_nxt;
      den2_r    <= den2_nxt;
      direct2_r <= direct2_nxt;
    end
  end

  // Stage 3: |x| plus rounding half step, one adder with carry-in
  logic                valid3_r;
  logic [NUMA_W-1:0]   num3_r;
  logic [DENA_W-1:0]   den3_r;
  side_a_t             side3_r;
  logic                neg3;
  logic [XA_W-1:0]     mag3;

  assign neg3 = x2_r[XA_W-1];
  assign mag3 = (neg3 ? ~x2_r : x2_r) + XA_W'(half2_r) + XA_W'(neg3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid3_r <= 1'b0;
    end else if (en) begin
      valid3_r <= valid2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num3_r         <= mag3[NUMA_W-1:0];
      den3_r         <= den2_r;
      side3_r.path   <= path2_r;
      side3_r.neg    <= neg3;
      side3_r.direct <= direct2_r;
    end
  end

  assign out_valid = valid3_r;
  assign out_num   = num3_r;
  assign out_den   = den3_r;
  assign out_side  = side3_r;

endmodule

### design/regulator_voltage_code_converter_core.sv
// Top level of the regulator output-voltage code converter: item channels, config port, pipeline.
//
// Converts one item per clock, unless the result side stalls, between a rail's voltage
// register code and millivolts (kind 0: code to mV, kind 1: mV to code) in the format
// held in code_format: 5 mV VID, base plus step, LINEAR16 exponent -12 or -9; formats 4
// to 7 give zero. The block holds no state between items, so a new item is taken every
// cycle while the result side does not stall. Each item passes 47 registers: operand
// preparation (products, format decode, signed magnitude), divider A, sign fix-up,
// reciprocal multiplication for the final /1000 of the step decode and the output
// register. The pipeline length is set mostly by the restoring divider, which retires one
// quotient bit per stage; every item walks the whole pipeline, whatever its format. A
// stall on the result side freezes the whole pipeline only once the stage ahead of the
// output register holds an item, so bubbles are squeezed out while a finished result
// waits. Registers are to be written over the APB-style port (byte address 4*i) only
// while no item is in flight; the block itself does not enforce this. They are read
// live by the pipeline.
module regulator_voltage_code_converter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  rvcc_in_if.sink                         in_ch,
  rvcc_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rvcc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rvcc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rvcc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import rvcc_pkg::*;

  localparam int QA_DIVQ_W = 30;  // quotient bits a plain division can reach
  localparam int QB_MV_W   = 20;  // millivolt magnitude bits of the step decode

  cfg_t cfg;

  rvcc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline advance: output slot free, being drained, or nothing arriving at it
  logic               adv;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [VALUE_W-1:0] out_conv_r;
  logic [VALUE_W-1:0] out_conv_nxt;
  logic               qb_valid;
  logic [NUMB_W-1:0]  qb_quo;
  side_b_t            qb_side;

  assign adv         = out_ch.ready | ~out_valid_r | ~qb_valid;
  assign in_ch.ready = adv;

  // Prep: three stages into divider A
  logic              pa_valid;
  logic [NUMA_W-1:0] pa_num;
  logic [DENA_W-1:0] pa_den;
  side_a_t           pa_side;

  rvcc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_value  (in_ch.value),
    .cfg       (cfg),
    .out_valid (pa_valid),
    .out_num   (pa_num),
    .out_den   (pa_den),
    .out_side  (pa_side)
  );

  // Divider A: every run-time division (by 5, by 1000, by the step)
  logic              qa_valid;
  logic [NUMA_W-1:0] qa_quo;
  logic [SIDEA_W-1:0] qa_side_bits;
  side_a_t           qa_side;

  rvcc_div #(
    .NUM_W  (NUMA_W),
    .DEN_W  (DENA_W),
    .SIDE_W (SIDEA_W)
  ) u_div_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (pa_valid),
    .in_num    (pa_num),
    .in_den    (pa_den),
    .in_side   (SIDEA_W'(pa_side)),
    .out_valid (qa_valid),
    .out_quo   (qa_quo),
    .out_side  (qa_side_bits)
  );

  assign qa_side = side_a_t'(qa_side_bits);

  // Mid 1: apply the sign of quotient A.
  // Step decode continues as base_uv + q + 500; other paths settle their 16-bit result here.
  logic                   m1_valid_r;
  logic signed [XB_W-1:0] m1_x_r;
  side_b_t                m1_side_r;
  logic signed [XB_W-1:0] m1_x_nxt;
  side_b_t                m1_side_nxt;
  logic [XB_W-1:0]        qa_ext;
  logic [VALUE_W-1:0]     qa_low;

  always_comb begin
    qa_ext   = XB_W'(qa_quo);
    qa_low   = qa_quo[VALUE_W-1:0];
    m1_x_nxt = $signed(XB_W'(cfg.base_uv) + XB_W'(ROUND_HALF)
                       + (qa_side.neg ? ~qa_ext : qa_ext) + XB_W'(qa_side.neg));
    m1_side_nxt.step_c2m = (qa_side.path == PATH_STEP_C2M);
    m1_side_nxt.neg      = 1'b0;
    case (qa_side.path)
      PATH_DIRECT:   m1_side_nxt.res = qa_side.direct;
      PATH_DIVQ:     m1_side_nxt.res = qa_low;
      PATH_STEP_M2C: m1_side_nxt.res = cfg.base_code + (qa_side.neg ? ~qa_low : qa_low)
                                       + VALUE_W'(qa_side.neg);
      default:       m1_side_nxt.res = '0;   // step decode finishes after the /1000
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
    end else if (adv) begin
      m1_valid_r <= qa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_x_r    <= m1_x_nxt;
      m1_side_r <= m1_side_nxt;
    end
  end

  // Mid 2: magnitude for the truncating /1000
  logic              m2_valid_r;
  logic [NUMB_W-1:0] m2_num_r;
  side_b_t           m2_side_r;
  logic              m2_neg;
  logic [XB_W-1:0]   m2_mag;

  assign m2_neg = m1_x_r[XB_W-1];
  assign m2_mag = (m2_neg ? ~m1_x_r : m1_x_r) + XB_W'(m2_neg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_valid_r <= 1'b0;
    end else if (adv) begin
      m2_valid_r <= m1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_num_r           <= m2_mag[NUMB_W-1:0];
      m2_side_r.step_c2m <= m1_side_r.step_c2m;
      m2_side_r.neg      <= m2_neg;
      m2_side_r.res      <= m1_side_r.res;
    end
  end

  // Truncating /1000 by reciprocal: the magnitude is below 2^30, so multiplying by
  // ceil(2^40/1000) and dropping 40 bits is exact. The numerator is split in two
  // halves, one short product each in the first stage, summed in the second.
  localparam int PP_W   = NUMB_HALF_W + MV_RECIP_W;
  localparam int PROD_W = NUMB_W + MV_RECIP_W;

  logic              b1_valid_r;
  logic [PP_W-1:0]   b1_hi_r;
  logic [PP_W-1:0]   b1_lo_r;
  side_b_t           b1_side_r;
  logic [PP_W-1:0]   b1_hi_nxt;
  logic [PP_W-1:0]   b1_lo_nxt;
  logic [PROD_W-1:0] b2_prod;
  logic              qb_valid_r;
  logic [NUMB_W-1:0] qb_quo_r;
  side_b_t           qb_side_r;

  assign b1_hi_nxt = PP_W'(m2_num_r[NUMB_W-1:NUMB_HALF_W]) * PP_W'(MV_RECIP);
  assign b1_lo_nxt = PP_W'(m2_num_r[NUMB_HALF_W-1:0]) * PP_W'(MV_RECIP);
  assign b2_prod   = (PROD_W'(b1_hi_r) << NUMB_HALF_W) + PROD_W'(b1_lo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
      qb_valid_r <= 1'b0;
    end else if (adv) begin
      b1_valid_r <= m2_valid_r;
      qb_valid_r <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_hi_r   <= b1_hi_nxt;
      b1_lo_r   <= b1_lo_nxt;
      b1_side_r <= m2_side_r;
      qb_quo_r  <= NUMB_W'(b2_prod >> MV_RECIP_SHIFT);
      qb_side_r <= b1_side_r;
    end
  end

  assign qb_valid = qb_valid_r;
  assign qb_quo   = qb_quo_r;
  assign qb_side  = qb_side_r;

  // Output register
  logic [VALUE_W-1:0] qb_low;

  always_comb begin
    qb_low        = qb_quo[VALUE_W-1:0];
    out_conv_nxt  = out_conv_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv && qb_valid) begin
      out_valid_nxt = 1'b1;
      if (qb_side.step_c2m) begin
        out_conv_nxt = (qb_side.neg ? ~qb_low : qb_low) + VALUE_W'(qb_side.neg);
      end else begin
        out_conv_nxt = qb_side.res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_conv_r <= out_conv_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.converted = out_conv_r;

  // Checks
  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(qb_valid))
    else $error("result appeared without an item at the end of the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && qb_valid) |=> (qb_valid && $stable(qb_quo)))
    else $error("stage ahead of the output changed during a stall");

  a_quo_a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (qa_valid && qa_side.path == PATH_DIVQ) |-> (qa_quo[NUMA_W-1:QA_DIVQ_W] == '0))
    else $error("plain division quotient out of range");

  a_quo_b_range: assert property (@(posedge clk) disable iff (!rst_n)
    (qb_valid && qb_side.step_c2m) |-> (qb_quo[NUMB_W-1:QB_MV_W] == '0))
    else $error("step decode millivolts out of range");

endmodule
